### sv/kxs_pkg.sv
// Shared types, codes and xorshift helper functions for the keyed xorshift sampler.
// No dependencies; every other file imports this package.
`default_nettype none

package kxs_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CNT_W   = 6;            // divider step counter, WORD_W steps
  localparam int unsigned IN_W    = 3 * WORD_W;   // key_i, key_j, modulus
  localparam int unsigned OUT_W   = 2 * WORD_W;   // raw_word, sample_value
  localparam int unsigned FLAG_W  = 2;            // hit, divide_error

  localparam logic [WORD_W-1:0] SEED_RESET = 64'd11515616;
  localparam logic [CNT_W-1:0]  DIV_LAST   = {CNT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ADVANCE  = 2'd0,
    CMD_KEYLESS  = 2'd1,
    CMD_ONE_KEY  = 2'd2,
    CMD_TWO_KEY  = 2'd3
  } cmd_t;

  // Datapath operation for the work register in one cycle.
  typedef enum logic [2:0] {
    STEP_NONE  = 3'd0,
    STEP_ADV   = 3'd1,  // state and work <= scramble_a(state)
    STEP_MIXS  = 3'd2,  // work <= mix_a(state)
    STEP_ADDA  = 3'd3,  // work <= state + scramble_a(key_i)
    STEP_MIXA  = 3'd4,  // work <= mix_a(work)
    STEP_ADDB  = 3'd5,  // work <= work + scramble_b(key_j)
    STEP_MIXB  = 3'd6   // work <= mix_b(work)
  } step_t;

  typedef struct packed {
    logic  load;      // capture the input request
    step_t step;
    logic  div_init;  // copy work word into divider, clear remainder
    logic  div_step;  // one restoring divider iteration
    logic  out_load;  // move finished result into the output register
  } kxs_ctl_t;

  typedef struct packed {
    cmd_t cmd;        // command of the request in flight
  } kxs_stat_t;

  function automatic logic [WORD_W-1:0] scramble_a(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    t = v ^ (v << 19);
    t = t ^ (t >> 7);
    t = t ^ (t << 36);
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] mix_a(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    t = v ^ (v << 38);
    t = t ^ (t >> 13);
    t = t ^ (t << 23);
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] scramble_b(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    t = v ^ (v >> 7);
    t = t ^ (t << 23);
    t = t ^ (t >> 8);
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] mix_b(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    t = v ^ (v >> 7);
    t = t ^ (t << 53);
    t = t ^ (t >> 4);
    return t;
  endfunction

endpackage

`default_nettype wire

### sv/keyed_xorshift_sampler.sv
// Top level of the keyed xorshift sampler: joins the sequencer and the datapath
// and maps them onto stream channels. Depends on kxs_pkg, kxs_ctrl, kxs_dpath.
//
// Usage:
//   A request enters on the s_axis channel: tuser carries the command (advance,
//   keyless draw, one-key draw, two-key draw), tdata the two keys and the
//   modulus. One result leaves on m_axis for every request: tdata carries the
//   raw word and its remainder by the modulus, tuser the hit and divide-error
//   flags. The seed is to be written through cfg_we/cfg_wdata only while the block
//   is idle; the block does not enforce this. A write also loads the generator state.
//   Each request runs one to four mixing steps (advance and keyless take one,
//   one-key two, two-key four), one divider setup step, the 64 steps of the
//   bit-serial restoring divider and one output load, which waits while an
//   earlier result is still held. One request is in flight at a time; the next
//   is taken only once the sequencer is back in idle.
//   s_axis_tready is high only while the sequencer is idle. A finished result
//   waits in the output register; the next request is accepted while it waits,
//   and its own result is held back until the receiver takes the earlier one.
//   Reset clears the sequencer and output valid and loads the generator state
//   with the default seed 11515616.
`default_nettype none

module keyed_xorshift_sampler (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [kxs_pkg::WORD_W-1:0] cfg_wdata,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [kxs_pkg::IN_W-1:0]   s_axis_tdata,   // key_i, key_j, modulus
  input  wire logic [kxs_pkg::CMD_W-1:0]  s_axis_tuser,   // cmd
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [kxs_pkg::OUT_W-1:0]       m_axis_tdata,   // raw_word, sample_value
  output logic [kxs_pkg::FLAG_W-1:0]      m_axis_tuser    // hit, divide_error
);
  import kxs_pkg::*;

  kxs_ctl_t  ctl;
  kxs_stat_t stat;

  // Sequencer: owns the handshake and steps the datapath through each request.
  kxs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_cmd    (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Datapath: generator state, mixing, remainder and output register.
  kxs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .ctl       (ctl),
    .stat      (stat),
    .out_data  (m_axis_tdata),
    .out_flags (m_axis_tuser)
  );

  // Busy after a request is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sampler ready right after accepting a request");

  // A result load always raises output valid.
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> m_axis_tvalid)
    else $error("output valid missing after result load");

  // A zero modulus reports zero remainder and no hit.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata[OUT_W-1:WORD_W] == '0) && !m_axis_tuser[0])
    else $error("divide error with nonzero sample or hit");

  // A hit means the remainder is zero.
  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[OUT_W-1:WORD_W] == '0))
    else $error("hit flagged with nonzero remainder");

endmodule

`default_nettype wire

### sv/kxs_ctrl.sv
// Sequencer for the keyed xorshift sampler: issues mixing steps, divider steps
// and output loads to the datapath. Depends on kxs_pkg.
`default_nettype none

module kxs_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [kxs_pkg::CMD_W-1:0] in_cmd,
  output logic                          in_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  input  wire kxs_pkg::kxs_stat_t       stat,
  output kxs_pkg::kxs_ctl_t             ctl
);
  import kxs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ADV   = 10'b0000000010,
    S_MIXS  = 10'b0000000100,
    S_ADDA  = 10'b0000001000,
    S_MIXA  = 10'b0000010000,
    S_ADDB  = 10'b0000100000,
    S_MIXB  = 10'b0001000000,
    S_DINIT = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.step     = STEP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          unique case (cmd_t'(in_cmd))
            CMD_ADVANCE: state_next = S_ADV;
            CMD_KEYLESS: state_next = S_MIXS;
            CMD_ONE_KEY,
            CMD_TWO_KEY: state_next = S_ADDA;
            default:     state_next = S_ADDA;
          endcase
        end
      end
      S_ADV: begin
        ctl.step   = STEP_ADV;
        state_next = S_DINIT;
      end
      S_MIXS: begin
        ctl.step   = STEP_MIXS;
        state_next = S_DINIT;
      end
      S_ADDA: begin
        ctl.step   = STEP_ADDA;
        state_next = S_MIXA;
      end
      S_MIXA: begin
        ctl.step   = STEP_MIXA;
        state_next = (stat.cmd == CMD_TWO_KEY) ? S_ADDB : S_DINIT;
      end
      S_ADDB: begin
        ctl.step   = STEP_ADDB;
        state_next = S_MIXB;
      end
      S_MIXB: begin
        ctl.step   = STEP_MIXB;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        ctl.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt == DIV_LAST) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.div_init) cnt <= '0;
      else if (ctl.div_step) cnt <= cnt + 1'b1;
      if (ctl.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/kxs_dpath.sv
// Datapath of the keyed xorshift sampler: generator state, xorshift mixing,
// restoring remainder unit and output register. Depends on kxs_pkg.
`default_nettype none

module kxs_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [kxs_pkg::WORD_W-1:0] cfg_wdata,
  input  wire logic [kxs_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [kxs_pkg::IN_W-1:0]   in_data,
  input  wire kxs_pkg::kxs_ctl_t         ctl,
  output kxs_pkg::kxs_stat_t             stat,
  output logic [kxs_pkg::OUT_W-1:0]      out_data,
  output logic [kxs_pkg::FLAG_W-1:0]     out_flags
);
  import kxs_pkg::*;

  logic [WORD_W-1:0] gen_state;
  cmd_t              cmd_q;
  logic [WORD_W-1:0] key_i, key_j, modulus;
  logic [WORD_W-1:0] work;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] rem;
  logic [WORD_W:0]   trial, diff;
  logic              ge;
  logic [WORD_W-1:0] work_next;
  logic              mod_zero;

  assign stat.cmd = cmd_q;

  // Restoring divider: shift in one dividend bit, subtract when it fits.
  assign trial    = {rem, dvd[WORD_W-1]};
  assign diff     = trial - {1'b0, modulus};
  assign ge       = !diff[WORD_W];
  assign mod_zero = (modulus == '0);

  always_comb begin
    unique case (ctl.step)
      STEP_ADV:  work_next = scramble_a(gen_state);
      STEP_MIXS: work_next = mix_a(gen_state);
      STEP_ADDA: work_next = gen_state + scramble_a(key_i);
      STEP_MIXA: work_next = mix_a(work);
      STEP_ADDB: work_next = work + scramble_b(key_j);
      STEP_MIXB: work_next = mix_b(work);
      default:   work_next = work;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SEED_RESET;
    end else if (cfg_we) begin
      gen_state <= cfg_wdata;
    end else if (ctl.step == STEP_ADV) begin
      gen_state <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= cmd_t'(in_cmd);
      key_i   <= in_data[WORD_W-1:0];
      key_j   <= in_data[2*WORD_W-1:WORD_W];
      modulus <= in_data[3*WORD_W-1:2*WORD_W];
    end
    work <= work_next;
    if (ctl.div_init) begin
      word <= work;
      dvd  <= work;
      rem  <= '0;
    end else if (ctl.div_step) begin
      dvd <= dvd << 1;
      rem <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    end
    if (ctl.out_load) begin
      out_data[WORD_W-1:0]      <= word;
      out_data[OUT_W-1:WORD_W]  <= mod_zero ? '0 : rem;
      out_flags[0]              <= !mod_zero && (rem == '0);
      out_flags[1]              <= mod_zero;
    end
  end

endmodule

`default_nettype wire

### test/tb_keyed_xorshift_sampler.sv
// Self-checking bench for keyed_xorshift_sampler: a directed table of requests, then random
// requests across several seeds, each result checked against an in-bench predictor.
// Depends on kxs_pkg (widths, command enum, reset seed) and the keyed_xorshift_sampler RTL.
`timescale 1ns / 1ps

module tb_keyed_xorshift_sampler;
  import kxs_pkg::*;

  localparam int HALF_PERIOD_NS  = 2;
  localparam int RESET_CYCLES    = 12;
  localparam int MAX_GAP         = 17;
  localparam int LONG_HOLD       = 600;   // receiver hold-off, long enough to back up the input
  localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no handshake anywhere
  localparam int TAIL_CYCLES     = 80;    // idle tail after the last sample has drained
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int DIR_ROWS        = 20;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    cmd_t  cmd;
    word_t key_i;
    word_t key_j;
    word_t modulus;
  } request_t;

  typedef struct packed {
    word_t raw_word;
    word_t sample_value;
    logic  hit;
    logic  divide_error;
  } sample_t;

  // One line of the directed table: optionally reload the seed first, then send the request.
  // Where the outcome is obvious the expected sample is typed in, else the predictor decides.
  typedef struct packed {
    logic     load_seed;
    word_t    seed;
    request_t req;
    logic     typed;
    sample_t  want;
  } dir_row_t;

  localparam word_t   ZERO    = '0;
  localparam word_t   ONES    = '1;
  localparam word_t   TOP_BIT = {1'b1, {(WORD_W-1){1'b0}}};
  localparam sample_t NO_WANT = '0;
  // With a zero state and zero keys every path yields a zero word.
  localparam sample_t ZERO_WORD_HIT     = '{ZERO, ZERO, 1'b1, 1'b0};
  localparam sample_t ZERO_WORD_DIV_ERR = '{ZERO, ZERO, 1'b0, 1'b1};

  dir_row_t dir_rows [DIR_ROWS] = '{
    // reset seed
    '{1'b0, ZERO, '{CMD_KEYLESS, ZERO, ZERO, ZERO}, 1'b0, NO_WANT},       // zero modulus
    '{1'b0, ZERO, '{CMD_ADVANCE, ONES, ONES, 64'd1}, 1'b0, NO_WANT},      // keys ignored
    '{1'b0, ZERO, '{CMD_ONE_KEY, ONES, ZERO, ONES}, 1'b0, NO_WANT},
    '{1'b0, ZERO, '{CMD_TWO_KEY, ZERO, ONES, TOP_BIT}, 1'b0, NO_WANT},
    '{1'b0, ZERO, '{CMD_TWO_KEY, ONES, ZERO, 64'd3}, 1'b0, NO_WANT},
    '{1'b0, ZERO, '{CMD_ONE_KEY, ZERO, ONES, 64'd2}, 1'b0, NO_WANT},      // key_j ignored
    '{1'b0, ZERO, '{CMD_ADVANCE, ZERO, ZERO, ZERO}, 1'b0, NO_WANT},       // advance, no divisor
    // zero seed: words from zero keys are zero, so hits and errors can be typed in
    '{1'b1, ZERO, '{CMD_KEYLESS, ZERO, ZERO, ZERO}, 1'b1, ZERO_WORD_DIV_ERR},
    '{1'b0, ZERO, '{CMD_ONE_KEY, ZERO, ONES, 64'd7}, 1'b1, ZERO_WORD_HIT},
    '{1'b0, ZERO, '{CMD_TWO_KEY, ZERO, ZERO, ONES}, 1'b1, ZERO_WORD_HIT},
    '{1'b0, ZERO, '{CMD_ADVANCE, ONES, ONES, 64'd1}, 1'b1, ZERO_WORD_HIT},
    '{1'b0, ZERO, '{CMD_TWO_KEY, ZERO, ZERO, ZERO}, 1'b1, ZERO_WORD_DIV_ERR},
    '{1'b0, ZERO, '{CMD_ONE_KEY, 64'd1, ZERO, ONES}, 1'b0, NO_WANT},
    // all-ones seed
    '{1'b1, ONES, '{CMD_KEYLESS, ZERO, ZERO, ONES}, 1'b0, NO_WANT},
    '{1'b0, ZERO, '{CMD_ADVANCE, ZERO, ZERO, TOP_BIT}, 1'b0, NO_WANT},
    '{1'b0, ZERO, '{CMD_TWO_KEY, ONES, ONES, 64'd2}, 1'b0, NO_WANT},
    '{1'b0, ZERO, '{CMD_ONE_KEY, TOP_BIT, ZERO, 64'd1}, 1'b0, NO_WANT},
    // seed of one
    '{1'b1, 64'd1, '{CMD_ADVANCE, ZERO, ZERO, 64'd5}, 1'b0, NO_WANT},
    '{1'b0, ZERO, '{CMD_TWO_KEY, TOP_BIT, TOP_BIT, ZERO}, 1'b0, NO_WANT},
    '{1'b0, ZERO, '{CMD_KEYLESS, ZERO, ZERO, 64'd1}, 1'b0, NO_WANT}
  };

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_we        = 1'b0;
  word_t                cfg_wdata     = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;  // key_i, key_j, modulus
  logic [CMD_W-1:0]     s_axis_tuser  = '0;  // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;        // raw_word, sample_value
  logic [FLAG_W-1:0]    m_axis_tuser;        // hit, divide_error

  // Predictor state and the queue of samples still owed by the block.
  word_t     gen_state;
  sample_t   pending_samples [$];
  int        mismatches    = 0;
  int        idle_cycles   = 0;
  bit        sender_calm   = 1'b0;
  bit        receiver_calm = 1'b0;
  bit        hold_request  = 1'b0;

  keyed_xorshift_sampler dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  // Xorshift passes: left 19 / right 7 / left 36 both advances the state and scrambles key_i.
  function automatic word_t advance_mix(word_t v);
    v = v ^ (v << 19);
    v = v ^ (v >> 7);
    return v ^ (v << 36);
  endfunction

  function automatic word_t draw_mix(word_t v);
    v = v ^ (v << 38);
    v = v ^ (v >> 13);
    return v ^ (v << 23);
  endfunction

  function automatic word_t column_scramble(word_t v);
    v = v ^ (v >> 7);
    v = v ^ (v << 23);
    return v ^ (v >> 8);
  endfunction

  function automatic word_t pair_mix(word_t v);
    v = v ^ (v >> 7);
    v = v ^ (v << 53);
    return v ^ (v >> 4);
  endfunction

  // Work out the sample for one accepted request; advance also moves the generator state.
  function automatic sample_t predict_sample(request_t r);
    word_t   w;
    sample_t s;
    case (r.cmd)
      CMD_ADVANCE: begin
        gen_state = advance_mix(gen_state);
        w = gen_state;
      end
      CMD_KEYLESS: w = draw_mix(gen_state);
      default: begin
        w = draw_mix(gen_state + advance_mix(r.key_i));
        if (r.cmd == CMD_TWO_KEY) w = pair_mix(w + column_scramble(r.key_j));
      end
    endcase
    s.raw_word     = w;
    s.divide_error = (r.modulus == '0);
    s.sample_value = s.divide_error ? '0 : w % r.modulus;
    s.hit          = !s.divide_error && (s.sample_value == '0);
    return s;
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Keys are mostly random words, with row/column-like small indexes and the extremes thrown in.
  function automatic word_t rand_key();
    case ($urandom_range(0, 7))
      0: return ZERO;
      1: return ONES;
      2: return word_t'($urandom_range(0, 255));
      default: return rand_word();
    endcase
  endfunction

  // Small divisors make hits common; zero exercises the error path.
  function automatic word_t rand_modulus();
    case ($urandom_range(0, 9))
      0:       return ZERO;
      1, 2:    return word_t'($urandom_range(1, 16));
      3:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
      4:       return ONES;
      5:       return rand_word() >> $urandom_range(1, WORD_W - 2);
      default: return rand_word();
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t r;
    r.cmd     = cmd_t'($urandom_range(0, 3));
    r.key_i   = rand_key();
    r.key_j   = rand_key();
    r.modulus = rand_modulus();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatches++;
    $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
  endtask

  // Offer one request after a random gap, hold it until accepted, then queue its sample.
  task automatic issue_request(input request_t r, input bit typed, input sample_t want);
    int      gap;
    sample_t predicted;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.modulus, r.key_j, r.key_i};
    s_axis_tuser  <= r.cmd;
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_sample(r);
    pending_samples.insert(pending_samples.size(), typed ? want : predicted);
  endtask

  // Drop valid and stall until every owed sample has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  // Write the seed; the block copies it into the generator state at once.
  task automatic load_seed(input word_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_state = value;
  endtask

  // Stimulus: directed table, then random phases each opened with a fresh seed.
  initial begin
    word_t phase_seed;
    gen_state = SEED_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].load_seed) begin
        wait_drained();
        load_seed(dir_rows[i].seed);
      end
      issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // Reconfigure only with nothing in flight.
      wait_drained();
      phase_seed = (p == 1) ? ONES : (p == 3) ? ZERO : (p == 4) ? TOP_BIT : rand_word();
      load_seed(phase_seed);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Re-roll the idling style now and then so back-to-back stretches appear.
        if (n % 50 == 0) begin
          sender_calm   = ($urandom_range(0, 3) == 0);
          receiver_calm = ($urandom_range(0, 3) == 0);
        end
        // Ask the receiver for a long hold-off and keep the requests coming meanwhile.
        if (n == 100 && (p == 1 || p == 4)) begin
          hold_request = 1'b1;
          sender_calm  = 1'b1;
        end
        issue_request(rand_request(), 1'b0, NO_WANT);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stall before taking each sample, plus the occasional long hold.
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Compare each accepted sample with the oldest one owed, field by field.
  always @(posedge clk) begin
    sample_t got;
    sample_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[WORD_W-1:0], m_axis_tdata[OUT_W-1:WORD_W],
              m_axis_tuser[0], m_axis_tuser[1]};
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected sample, raw_word", got.raw_word, ZERO);
      end else begin
        want = pending_samples.pop_front();
        if (got.raw_word !== want.raw_word)
          report_mismatch("raw_word", got.raw_word, want.raw_word);
        if (got.sample_value !== want.sample_value)
          report_mismatch("sample_value", got.sample_value, want.sample_value);
        if (got.hit !== want.hit)
          report_mismatch("hit", word_t'(got.hit), word_t'(want.hit));
        if (got.divide_error !== want.divide_error)
          report_mismatch("divide_error", word_t'(got.divide_error), word_t'(want.divide_error));
      end
    end
  end

  // Watchdog: give up when no request, sample or seed write moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### keyed_xorshift_sampler.f
sv/kxs_pkg.sv
sv/kxs_ctrl.sv
sv/kxs_dpath.sv
sv/keyed_xorshift_sampler.sv
test/tb_keyed_xorshift_sampler.sv
